FILE: design/debug_packet_deframer_assert.svh
// Assertion macros shared by the deframer checker.
// Depends on nothing; the including file supplies clock and reset names.
`ifndef DEBUG_PACKET_DEFRAMER_ASSERT_SVH
`define DEBUG_PACKET_DEFRAMER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define DPD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("deframer check failed");

// Next-cycle implication, disabled while reset is asserted
`define DPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

FILE: design/dpd_pkg.sv
// Shared types, constants and helpers for the debug packet deframer.
// No dependencies.
package dpd_pkg;

  localparam int unsigned BUFFER_BYTES_DEF = 512;
  localparam int unsigned IDX_W            = 9;
  localparam int unsigned MAX_RES          = 4;

  // Framing characters
  localparam logic [7:0] CH_START = 8'h24;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_ACK   = 8'h2B;
  localparam logic [7:0] CH_NAK   = 8'h2D;
  localparam logic [7:0] CH_COLON = 8'h3A;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_TX      = 2'd1,
    KIND_END     = 2'd2,
    KIND_ABANDON = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_SUM_HI  = 2'd2,
    PH_SUM_LO  = 2'd3
  } phase_e;

  typedef struct packed {
    kind_e             kind;
    logic [7:0]        data;
    logic [IDX_W-1:0]  idx;
    logic              good;
    logic              seq;
    logic [IDX_W-1:0]  len;
  } res_t;

  // All results caused by one received byte
  typedef struct packed {
    res_t [MAX_RES-1:0] ent;
    logic [2:0]         cnt;
  } burst_t;

  // Hex digit value, or 8'hFF (minus one) when not a hex digit
  function automatic logic [7:0] digit_value(logic [7:0] c);
    logic [7:0] v;
    v = 8'hFF;
    if (c >= 8'h61 && c <= 8'h66) v = c - 8'h61 + 8'd10;
    else if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30;
    else if (c >= 8'h41 && c <= 8'h46) v = c - 8'h41 + 8'd10;
    return v;
  endfunction

endpackage

FILE: design/dpd_parse.sv
// Framing parser: holds the packet state and turns one byte into its results.
// Depends on dpd_pkg.
module dpd_parse #(
  parameter int unsigned BUFFER_BYTES = dpd_pkg::BUFFER_BYTES_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [7:0]      byte_i,
  input  logic            advance_i,
  output dpd_pkg::burst_t burst_o
);

  localparam int unsigned        CNT_W     = $clog2(BUFFER_BYTES);
  localparam logic [CNT_W-1:0]   CNT_LIMIT = CNT_W'(BUFFER_BYTES - 1);

  dpd_pkg::phase_e  phase_q, phase_d;
  logic [7:0]       sum_q, sum_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]       hi_q, hi_d;
  logic [15:0]      seq_q, seq_d;
  logic             colon_q, colon_d;

  logic [CNT_W-1:0]  cnt_inc;
  logic [CNT_W+8:0]  cnt_ext, inc_ext;
  logic [7:0]        dval, sent;
  logic              seq_ok;

  assign cnt_inc = cnt_q + CNT_W'(1);
  assign cnt_ext = (CNT_W + 9)'(cnt_q);
  assign inc_ext = (CNT_W + 9)'(cnt_inc);
  assign dval    = dpd_pkg::digit_value(byte_i);
  assign sent    = hi_q + dval;
  assign seq_ok  = (cnt_q >= CNT_W'(3)) && colon_q;

  // Next state and result list for the byte at the input
  always_comb begin
    phase_d = phase_q;
    sum_d   = sum_q;
    cnt_d   = cnt_q;
    hi_d    = hi_q;
    seq_d   = seq_q;
    colon_d = colon_q;
    burst_o = '0;
    unique case (phase_q)
      dpd_pkg::PH_HUNT: begin
        if (byte_i == dpd_pkg::CH_START) begin
          phase_d = dpd_pkg::PH_PAYLOAD;
          sum_d   = '0;
          cnt_d   = '0;
          hi_d    = '0;
          seq_d   = '0;
          colon_d = 1'b0;
        end
      end
      dpd_pkg::PH_PAYLOAD: begin
        if (byte_i == dpd_pkg::CH_START) begin
          burst_o.ent[0].kind = dpd_pkg::KIND_ABANDON;
          burst_o.ent[0].len  = cnt_ext[8:0];
          burst_o.cnt         = 3'd1;
          sum_d   = '0;
          cnt_d   = '0;
          hi_d    = '0;
          seq_d   = '0;
          colon_d = 1'b0;
        end else if (byte_i == dpd_pkg::CH_HASH) begin
          phase_d = dpd_pkg::PH_SUM_HI;
        end else begin
          sum_d = sum_q + byte_i;
          if (cnt_q == CNT_W'(0)) seq_d[15:8] = byte_i;
          if (cnt_q == CNT_W'(1)) seq_d[7:0]  = byte_i;
          if (cnt_q == CNT_W'(2)) colon_d     = (byte_i == dpd_pkg::CH_COLON);
          cnt_d = cnt_inc;
          burst_o.ent[0].kind = dpd_pkg::KIND_PAYLOAD;
          burst_o.ent[0].data = byte_i;
          burst_o.ent[0].idx  = cnt_ext[8:0];
          burst_o.cnt         = 3'd1;
          // Buffer full: abandon and hunt again
          if (cnt_inc == CNT_LIMIT) begin
            burst_o.ent[1].kind = dpd_pkg::KIND_ABANDON;
            burst_o.ent[1].len  = inc_ext[8:0];
            burst_o.cnt         = 3'd2;
            phase_d             = dpd_pkg::PH_HUNT;
          end
        end
      end
      dpd_pkg::PH_SUM_HI: begin
        hi_d    = {dval[3:0], 4'h0};
        phase_d = dpd_pkg::PH_SUM_LO;
      end
      dpd_pkg::PH_SUM_LO: begin
        phase_d = dpd_pkg::PH_HUNT;
        if (sent == sum_q) begin
          burst_o.ent[0].kind = dpd_pkg::KIND_TX;
          burst_o.ent[0].data = dpd_pkg::CH_ACK;
          if (seq_ok) begin
            burst_o.ent[1].kind = dpd_pkg::KIND_TX;
            burst_o.ent[1].data = seq_q[15:8];
            burst_o.ent[2].kind = dpd_pkg::KIND_TX;
            burst_o.ent[2].data = seq_q[7:0];
            burst_o.ent[3].kind = dpd_pkg::KIND_END;
            burst_o.ent[3].good = 1'b1;
            burst_o.ent[3].seq  = 1'b1;
            burst_o.ent[3].len  = cnt_ext[8:0];
            burst_o.cnt         = 3'd4;
          end else begin
            burst_o.ent[1].kind = dpd_pkg::KIND_END;
            burst_o.ent[1].good = 1'b1;
            burst_o.ent[1].len  = cnt_ext[8:0];
            burst_o.cnt         = 3'd2;
          end
        end else begin
          burst_o.ent[0].kind = dpd_pkg::KIND_TX;
          burst_o.ent[0].data = dpd_pkg::CH_NAK;
          burst_o.ent[1].kind = dpd_pkg::KIND_END;
          burst_o.ent[1].len  = cnt_ext[8:0];
          burst_o.cnt         = 3'd2;
        end
      end
      default: phase_d = dpd_pkg::PH_HUNT;
    endcase
  end

  // Parser state, updated when the byte is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= dpd_pkg::PH_HUNT;
      sum_q   <= '0;
      cnt_q   <= '0;
      hi_q    <= '0;
      seq_q   <= '0;
      colon_q <= 1'b0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      sum_q   <= sum_d;
      cnt_q   <= cnt_d;
      hi_q    <= hi_d;
      seq_q   <= seq_d;
      colon_q <= colon_d;
    end
  end

endmodule

FILE: design/dpd_burst.sv
// Result register: holds the results of one byte and hands them out one per transfer.
// Depends on dpd_pkg.
module dpd_burst (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  dpd_pkg::burst_t burst_i,
  output logic            free_o,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [31:0]     m_axis_tdata,  // out_byte[7:0], payload_index[16:8], payload_length[25:17]
  output logic [3:0]      m_axis_tuser,  // out_kind[1:0], end_good[2], has_sequence[3]
  output logic            m_axis_tlast
);

  dpd_pkg::res_t [dpd_pkg::MAX_RES-1:0] ent_q;
  logic [2:0] cnt_q;
  logic [1:0] ptr_q;
  logic       valid_q;
  logic       at_last;
  logic       take;
  dpd_pkg::res_t cur;

  assign cur     = ent_q[ptr_q];
  assign at_last = (({1'b0, ptr_q} + 3'd1) == cnt_q);
  assign take    = valid_q && m_axis_tready;
  assign free_o  = !valid_q || (take && at_last);

  assign m_axis_tvalid = valid_q;
  assign m_axis_tlast  = at_last;
  assign m_axis_tdata  = {6'b0, cur.len, cur.idx, cur.data};
  assign m_axis_tuser  = {cur.seq, cur.good, cur.kind};

  // Control: pointer walks the held results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      ptr_q   <= '0;
      cnt_q   <= '0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      ptr_q   <= '0;
      cnt_q   <= burst_i.cnt;
    end else if (take) begin
      if (at_last) valid_q <= 1'b0;
      else         ptr_q   <= ptr_q + 2'd1;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (load_i) ent_q <= burst_i.ent;
  end

endmodule

FILE: design/debug_packet_deframer.sv
// Debug packet deframer:
//   s_axis carries received link bytes (tdata = rx_byte).
//   m_axis carries results: tuser gives the kind (payload byte, byte to send,
//   packet end, packet abandoned) with the end flags, tlast marks the final
//   result caused by one received byte.
// Path: a byte is registered in the input register on transfer, parsed from there,
//   and its results are loaded into the result register that drives m_axis.
// Throughput: one byte per cycle. A byte that closes a packet gives up to four
//   results, sent one per cycle from the result register; the next byte with
//   results waits until the last of them is taken. Bytes without results
//   (hunting, '#', first checksum digit) never wait on the output.
// Reset: the parser returns to hunting for '$' with all sums and counts cleared;
//   both registers are emptied.
// Stall: while m_axis_tready is low the current result holds, the next byte with
//   results is held in the input register, and s_axis_tready then drops.
// Depends on dpd_pkg, dpd_parse, dpd_burst.
module debug_packet_deframer #(
  parameter int unsigned BUFFER_BYTES = dpd_pkg::BUFFER_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // out_byte[7:0], payload_index[16:8], payload_length[25:17]
  output logic [3:0]  m_axis_tuser,   // out_kind[1:0], end_good[2], has_sequence[3]
  output logic        m_axis_tlast
);

  logic            in_valid_q;
  logic [7:0]      in_byte_q;
  logic            consume;
  logic            free;
  dpd_pkg::burst_t burst;

  // A byte leaves the input register when its results fit in the result register
  assign consume       = in_valid_q && ((burst.cnt == 3'd0) || free);
  assign s_axis_tready = !in_valid_q || consume;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (consume) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) in_byte_q <= s_axis_tdata;
  end

  dpd_parse #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (in_byte_q),
    .advance_i(consume),
    .burst_o  (burst)
  );

  dpd_burst u_burst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (consume && (burst.cnt != 3'd0)),
    .burst_i      (burst),
    .free_o       (free),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule

FILE: design/dpd_chk.sv
// Port-level checker for the debug packet deframer, bound to the top level.
// Depends on dpd_pkg and debug_packet_deframer_assert.svh.
`include "debug_packet_deframer_assert.svh"

module dpd_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [3:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  logic        is_payload, is_end, is_abandon;
  logic        stalled, has_seq, good_end, payload_clean, idx_zero;
  logic [36:0] m_word;

  assign is_payload = m_axis_tvalid && (m_axis_tuser[1:0] == dpd_pkg::KIND_PAYLOAD);
  assign is_end     = m_axis_tvalid && (m_axis_tuser[1:0] == dpd_pkg::KIND_END);
  assign is_abandon = m_axis_tvalid && (m_axis_tuser[1:0] == dpd_pkg::KIND_ABANDON);

  // Short names for the checked conditions
  assign stalled       = m_axis_tvalid && !m_axis_tready;
  assign m_word        = {m_axis_tlast, m_axis_tuser, m_axis_tdata};
  assign has_seq       = m_axis_tvalid && m_axis_tuser[3];
  assign good_end      = is_end && m_axis_tuser[2];
  assign payload_clean = (m_axis_tdata[25:17] == 9'd0) && (m_axis_tuser[3:2] == 2'b00);
  assign idx_zero      = (m_axis_tdata[16:8] == 9'd0);

  // Stalled result holds
  `DPD_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, stalled, m_axis_tvalid && $stable(m_word))
  // End and abandon always close the results of a byte
  `DPD_ASSERT_SAME(a_end_last, clk_i, rst_ni, is_end || is_abandon, m_axis_tlast)
  // Sequence echo only on a good end
  `DPD_ASSERT_SAME(a_seq_good, clk_i, rst_ni, has_seq, good_end)
  // Payload results carry no length and no end flags
  `DPD_ASSERT_SAME(a_payload_clean, clk_i, rst_ni, is_payload, payload_clean)
  // Only payload results carry an index
  `DPD_ASSERT_SAME(a_index_payload, clk_i, rst_ni, m_axis_tvalid && !is_payload, idx_zero)

endmodule

bind debug_packet_deframer dpd_chk u_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);

FILE: verif/debug_packet_deframer_tb.sv
// Self-checking testbench for debug_packet_deframer: drives link bytes on s_axis,
// predicts every m_axis result in-line and compares each transfer field by field.
// Depends on dpd_pkg and the debug_packet_deframer RTL.
`timescale 1ns / 100ps

module debug_packet_deframer_tb;

  localparam int unsigned BUF_BYTES    = dpd_pkg::BUFFER_BYTES_DEF;
  localparam int unsigned CYCLE_LIMIT  = 200_000;
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef logic [7:0] byte_q_t[$];

  // one expected m_axis transfer
  typedef struct packed {
    dpd_pkg::res_t res;
    logic          last;
  } frame_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // rx_byte[7:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;           // out_byte[7:0], payload_index[16:8], payload_length[25:17]
  logic [3:0]  m_axis_tuser;           // out_kind[1:0], end_good[2], has_sequence[3]
  logic        m_axis_tlast;

  frame_result_t pending_results[$];
  int unsigned   bytes_sent;
  int unsigned   results_seen;
  int unsigned   mismatch_count;
  int unsigned   cycle_count;
  int unsigned   src_idle_pct;
  int unsigned   snk_stall_pct;
  int unsigned   hold_left;

  // predictor state
  dpd_pkg::phase_e parse_phase = dpd_pkg::PH_HUNT;
  logic [7:0]      frame_sum = '0;
  int unsigned     frame_len;
  logic [7:0]      sum_high = '0;
  logic [15:0]     seq_echo = '0;
  logic            colon_third = 1'b0;

  debug_packet_deframer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // hex digit value; anything else counts as minus one
  function automatic logic [7:0] hex_value(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "A" && c <= "F") return c - "A" + 8'd10;
    if (c >= "a" && c <= "f") return c - "a" + 8'd10;
    return 8'hFF;
  endfunction

  function automatic dpd_pkg::res_t make_res(dpd_pkg::kind_e kind, logic [7:0] data,
                                             int unsigned idx, logic good, logic seq,
                                             int unsigned len);
    dpd_pkg::res_t r;
    r.kind = kind;
    r.data = data;
    r.idx  = idx[dpd_pkg::IDX_W-1:0];
    r.good = good;
    r.seq  = seq;
    r.len  = len[dpd_pkg::IDX_W-1:0];
    return r;
  endfunction

  function automatic void open_frame();
    parse_phase = dpd_pkg::PH_PAYLOAD;
    frame_sum   = '0;
    frame_len   = 0;
    sum_high    = '0;
    seq_echo    = '0;
    colon_third = 1'b0;
  endfunction

  // advance the parser by one accepted byte and queue the results it causes
  function automatic void deframe_byte(logic [7:0] c);
    dpd_pkg::res_t burst[$];
    logic [7:0]    sent;
    logic          seq;
    frame_result_t item;
    case (parse_phase)
      dpd_pkg::PH_HUNT: begin
        if (c == dpd_pkg::CH_START) open_frame();
      end
      dpd_pkg::PH_PAYLOAD: begin
        if (c == dpd_pkg::CH_START) begin
          // restart: abandon the partial packet
          burst.push_back(make_res(dpd_pkg::KIND_ABANDON, 8'h00, 0, 1'b0, 1'b0, frame_len));
          open_frame();
        end else if (c == dpd_pkg::CH_HASH) begin
          parse_phase = dpd_pkg::PH_SUM_HI;
        end else begin
          frame_sum = frame_sum + c;
          if (frame_len == 0) seq_echo[15:8] = c;
          if (frame_len == 1) seq_echo[7:0] = c;
          if (frame_len == 2) colon_third = (c == dpd_pkg::CH_COLON);
          burst.push_back(make_res(dpd_pkg::KIND_PAYLOAD, c, frame_len, 1'b0, 1'b0, 0));
          frame_len++;
          // buffer full: give up on this packet
          if (frame_len >= BUF_BYTES - 1) begin
            burst.push_back(make_res(dpd_pkg::KIND_ABANDON, 8'h00, 0, 1'b0, 1'b0,
                                     frame_len));
            parse_phase = dpd_pkg::PH_HUNT;
          end
        end
      end
      dpd_pkg::PH_SUM_HI: begin
        sum_high    = hex_value(c) << 4;
        parse_phase = dpd_pkg::PH_SUM_LO;
      end
      default: begin
        sent = sum_high + hex_value(c);
        if (sent == frame_sum) begin
          seq = (frame_len >= 3) && colon_third;
          burst.push_back(make_res(dpd_pkg::KIND_TX, dpd_pkg::CH_ACK, 0, 1'b0, 1'b0, 0));
          if (seq) begin
            burst.push_back(make_res(dpd_pkg::KIND_TX, seq_echo[15:8], 0, 1'b0, 1'b0, 0));
            burst.push_back(make_res(dpd_pkg::KIND_TX, seq_echo[7:0], 0, 1'b0, 1'b0, 0));
          end
          burst.push_back(make_res(dpd_pkg::KIND_END, 8'h00, 0, 1'b1, seq, frame_len));
        end else begin
          burst.push_back(make_res(dpd_pkg::KIND_TX, dpd_pkg::CH_NAK, 0, 1'b0, 1'b0, 0));
          burst.push_back(make_res(dpd_pkg::KIND_END, 8'h00, 0, 1'b0, 1'b0, frame_len));
        end
        parse_phase = dpd_pkg::PH_HUNT;
      end
    endcase
    foreach (burst[i]) begin
      item.res  = burst[i];
      item.last = (i == burst.size() - 1);
      pending_results.push_back(item);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: stalls and checking
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // four-state compare so that unknown outputs are caught
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    frame_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d byte %02h", m_axis_tuser[1:0], m_axis_tdata[7:0]);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("out_kind", 32'(want.res.kind), 32'(m_axis_tuser[1:0]));
        check_field("out_byte", 32'(want.res.data), 32'(m_axis_tdata[7:0]));
        check_field("payload_index", 32'(want.res.idx), 32'(m_axis_tdata[16:8]));
        check_field("payload_length", 32'(want.res.len), 32'(m_axis_tdata[25:17]));
        check_field("end_good", 32'(want.res.good), 32'(m_axis_tuser[2]));
        check_field("has_sequence", 32'(want.res.seq), 32'(m_axis_tuser[3]));
        check_field("last", 32'(want.last), 32'(m_axis_tlast));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Byte side
  // ---------------------------------------------------------------------------

  // offer one byte, with random idle cycles ahead of it, and wait for the transfer
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    deframe_byte(b);
    bytes_sent++;
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'h30 + n;
    return ($urandom_range(1) ? 8'h61 : 8'h41) + n - 8'd10;
  endfunction

  // payload bytes that are neither start nor hash
  function automatic byte_q_t random_body(int unsigned len, bit with_seq);
    byte_q_t     q;
    logic [7:0]  b;
    for (int unsigned i = 0; i < len; i++) begin
      b = 8'($urandom);
      if (b == dpd_pkg::CH_START || b == dpd_pkg::CH_HASH) b = b ^ 8'h80;
      q.push_back(b);
    end
    if (with_seq && len >= 3) q[2] = dpd_pkg::CH_COLON;
    return q;
  endfunction

  // whole packet; a corrupted checksum is sometimes sent as raw bytes
  task automatic send_frame(input byte_q_t body, input bit corrupt);
    logic [7:0] sum;
    logic [7:0] sent;
    sum = '0;
    foreach (body[i]) sum = sum + body[i];
    sent = corrupt ? (sum ^ 8'($urandom_range(255, 1))) : sum;
    send_byte(dpd_pkg::CH_START);
    foreach (body[i]) send_byte(body[i]);
    send_byte(dpd_pkg::CH_HASH);
    if (corrupt && $urandom_range(3) == 0) begin
      send_byte(8'($urandom));
      send_byte(8'($urandom));
    end else begin
      send_byte(hex_char(sent[7:4]));
      send_byte(hex_char(sent[3:0]));
    end
  endtask

  // stop offering and let every expected result come out
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_directed_frames();
    byte_q_t body;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    // ignored while hunting
    send_byte(8'h00);
    send_byte(8'hFF);
    // restart inside payload, then a packet with a sequence id
    send_byte(dpd_pkg::CH_START);
    send_byte(8'h41);
    body = '{8'h00, 8'hFF, dpd_pkg::CH_COLON};
    send_frame(body, 1'b0);
    // empty packet
    body = {};
    send_frame(body, 1'b0);
    // short packet, bad checksum
    body = '{dpd_pkg::CH_COLON, dpd_pkg::CH_COLON};
    send_frame(body, 1'b1);
    // both digits non-hex, start char as a digit: F0 + FF = EF
    send_byte(dpd_pkg::CH_START);
    send_byte(8'hEF);
    send_byte(dpd_pkg::CH_HASH);
    send_byte(dpd_pkg::CH_START);
    send_byte("z");
    // first digit non-hex, second lowercase: F0 + 0F = FF
    send_byte(dpd_pkg::CH_START);
    send_byte(8'hFF);
    send_byte(dpd_pkg::CH_HASH);
    send_byte("G");
    send_byte("f");
    wait_drained();
  endtask

  task automatic test_buffer_overflow();
    byte_q_t body;
    src_idle_pct  = 0;
    snk_stall_pct = 17;
    // longest packet that still fits
    body = random_body(BUF_BYTES - 2, 1'b1);
    send_frame(body, 1'b0);
    // one byte more runs into the limit
    body = random_body(BUF_BYTES - 1, 1'b0);
    send_byte(dpd_pkg::CH_START);
    foreach (body[i]) send_byte(body[i]);
    // back to hunting: these are ignored
    send_byte(dpd_pkg::CH_HASH);
    send_byte("0");
    wait_drained();
  endtask

  task automatic test_output_backpressure();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    hold_left     = 80;
    repeat (3) send_frame(random_body(8, 1'b1), 1'b0);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int unsigned src_pct, input int unsigned snk_pct,
                                     input int unsigned n_items);
    int unsigned first;
    int unsigned r;
    int unsigned len;
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    first         = bytes_sent;
    while (bytes_sent - first < n_items) begin
      r = $urandom_range(99);
      if (r < 8) begin
        // line noise
        send_byte(8'($urandom));
      end else if (r < 18) begin
        // broken packet: start and a few arbitrary bytes
        send_byte(dpd_pkg::CH_START);
        repeat ($urandom_range(4)) send_byte(8'($urandom));
      end else begin
        len = ($urandom_range(99) < 85) ? $urandom_range(10) : $urandom_range(60, 11);
        send_frame(random_body(len, $urandom_range(99) < 40), $urandom_range(99) < 25);
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_frames();
    test_buffer_overflow();
    test_output_backpressure();
    test_random_traffic(0, 0, 120);
    test_random_traffic(66, 0, 120);
    test_random_traffic(0, 66, 120);
    test_random_traffic(17, 17, 120);

    $display("Sent %0d link bytes and checked %0d result transfers", bytes_sent, results_seen);
    $display("Covered restarts, buffer overflow, non-hex checksums and output backpressure");
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/dpd_pkg.sv
design/dpd_parse.sv
design/dpd_burst.sv
design/debug_packet_deframer.sv
design/dpd_chk.sv
verif/debug_packet_deframer_tb.sv
